FILE: design/cfs_pkg.sv
// Shared types, codes and helpers for the cooler fault supervisor.
`timescale 1ns / 1ps
package cfs_pkg;

	// Command codes carried in the input transaction.
	localparam logic [2:0] CMD_TICK      = 3'd0;
	localparam logic [2:0] CMD_START     = 3'd1;
	localparam logic [2:0] CMD_STOP      = 3'd2;
	localparam logic [2:0] CMD_CLEAR     = 3'd3;
	localparam logic [2:0] CMD_FAST_STOP = 3'd4;

	// Fault codes.
	localparam logic [3:0] FAULT_NONE     = 4'd0;
	localparam logic [3:0] FAULT_FAN      = 4'd1;
	localparam logic [3:0] FAULT_HS_HOT   = 4'd2;
	localparam logic [3:0] FAULT_HOT_OPEN = 4'd3;
	localparam logic [3:0] FAULT_INT_HOT  = 4'd4;
	localparam logic [3:0] FAULT_COLD_LOW = 4'd5;
	localparam logic [3:0] FAULT_COLD_OPEN = 4'd6;
	localparam logic [3:0] FAULT_OVERCUR  = 4'd7;
	localparam logic [3:0] FAULT_GAIN     = 4'd8;
	localparam logic [3:0] FAULT_POWER    = 4'd9;

	// Run state codes as shown on the result channel.
	localparam logic [1:0] RUN_DISABLED = 2'd0;
	localparam logic [1:0] RUN_STARTUP  = 2'd1;
	localparam logic [1:0] RUN_AT_TEMP  = 2'd2;
	localparam logic [1:0] RUN_COOLING  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_SET_TEMP      = 3'd0;
	localparam logic [2:0] REG_HYST_OVER     = 3'd1;
	localparam logic [2:0] REG_HYST_UNDER    = 3'd2;
	localparam logic [2:0] REG_MAX_HEATSINK  = 3'd3;
	localparam logic [2:0] REG_MAX_INTERNAL  = 3'd4;
	localparam logic [2:0] REG_HOT_OPEN      = 3'd5;
	localparam logic [2:0] REG_COLD_LOW      = 3'd6;
	localparam logic [2:0] REG_COLD_OPEN     = 3'd7;

	typedef enum logic [3:0] {
		MODE_DISABLED = 4'b0001,
		MODE_STARTUP  = 4'b0010,
		MODE_AT_TEMP  = 4'b0100,
		MODE_COOLING  = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [15:0]        fan_rpm;
		logic signed [7:0]  hot_temp;
		logic signed [7:0]  internal_temp;
		logic signed [7:0]  cold_temp;
		logic               overcurrent_flag;
		logic               gain_ok;
		logic               power_fail_flag;
	} in_item_t;

	typedef struct packed {
		logic       drive_enable;
		logic [1:0] run_state;
		logic [3:0] fault_code;
		logic       watchdog_enabled;
		logic       watchdog_kick;
		logic       overcurrent_event;
	} out_item_t;

	typedef struct packed {
		logic signed [7:0] set_temp;
		logic [6:0]        hyst_over;
		logic [6:0]        hyst_under;
		logic signed [7:0] max_heatsink_temp;
		logic signed [7:0] max_internal_temp;
		logic signed [7:0] hot_open_limit;
		logic signed [7:0] cold_low_limit;
		logic signed [7:0] cold_open_limit;
	} cfg_t;

	typedef struct packed {
		mode_t      mode;
		logic [3:0] fault;
		logic       drive_on;
		logic       watchdog_on;
	} state_t;

	// Maps the one-hot mode to its two-bit run state code.
	function automatic logic [1:0] run_code(input mode_t m);
		logic [1:0] code;
		unique case (m)
			MODE_DISABLED: code = RUN_DISABLED;
			MODE_STARTUP:  code = RUN_STARTUP;
			MODE_AT_TEMP:  code = RUN_AT_TEMP;
			MODE_COOLING:  code = RUN_COOLING;
			default:       code = RUN_DISABLED;
		endcase
		return code;
	endfunction

endpackage

FILE: design/cfs_cfg_regs.sv
// Configuration register file of the cooler fault supervisor.
`timescale 1ns / 1ps
module cfs_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [2:0]      cfg_index,
	input  logic [7:0]      cfg_data,
	output cfs_pkg::cfg_t   cfg
);

	cfs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_temp          <= 8'sd5;
			cfg_q.hyst_over         <= 7'd1;
			cfg_q.hyst_under        <= 7'd1;
			cfg_q.max_heatsink_temp <= 8'sd60;
			cfg_q.max_internal_temp <= 8'sd70;
			cfg_q.hot_open_limit    <= -8'sd30;
			cfg_q.cold_low_limit    <= -8'sd10;
			cfg_q.cold_open_limit   <= 8'sd80;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cfs_pkg::REG_SET_TEMP:     cfg_q.set_temp          <= cfg_data;
				cfs_pkg::REG_HYST_OVER:    cfg_q.hyst_over         <= cfg_data[6:0];
				cfs_pkg::REG_HYST_UNDER:   cfg_q.hyst_under        <= cfg_data[6:0];
				cfs_pkg::REG_MAX_HEATSINK: cfg_q.max_heatsink_temp <= cfg_data;
				cfs_pkg::REG_MAX_INTERNAL: cfg_q.max_internal_temp <= cfg_data;
				cfs_pkg::REG_HOT_OPEN:     cfg_q.hot_open_limit    <= cfg_data;
				cfs_pkg::REG_COLD_LOW:     cfg_q.cold_low_limit    <= cfg_data;
				cfs_pkg::REG_COLD_OPEN:    cfg_q.cold_open_limit   <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/cfs_step.sv
// Next-state logic: fault tests, thermostat state machine and command decode.
`timescale 1ns / 1ps
module cfs_step (
	input  cfs_pkg::in_item_t item,
	input  cfs_pkg::cfg_t     cfg,
	input  cfs_pkg::state_t   cur,
	output cfs_pkg::state_t   nxt,
	output logic              kick,
	output logic              oc_event
);

	// Hysteresis levels span -255..254, so nine signed bits hold them without wrap.
	logic signed [8:0] stop_lvl;
	logic signed [8:0] start_lvl;
	logic signed [8:0] cold_ext;
	logic [3:0]        tick_fault;

	assign stop_lvl  = $signed({cfg.set_temp[7], cfg.set_temp}) - $signed({2'b00, cfg.hyst_over});
	assign start_lvl = $signed({cfg.set_temp[7], cfg.set_temp}) + $signed({2'b00, cfg.hyst_under});
	assign cold_ext  = $signed({item.cold_temp[7], item.cold_temp});

	// The last failing test in the list wins, so test from the end backward.
	always_comb begin
		priority if (!item.gain_ok)                             tick_fault = cfs_pkg::FAULT_GAIN;
		else if (item.overcurrent_flag)                         tick_fault = cfs_pkg::FAULT_OVERCUR;
		else if (item.cold_temp > cfg.cold_open_limit)          tick_fault = cfs_pkg::FAULT_COLD_OPEN;
		else if (item.cold_temp < cfg.cold_low_limit)           tick_fault = cfs_pkg::FAULT_COLD_LOW;
		else if (item.internal_temp > cfg.max_internal_temp)    tick_fault = cfs_pkg::FAULT_INT_HOT;
		else if (item.hot_temp < cfg.hot_open_limit)            tick_fault = cfs_pkg::FAULT_HOT_OPEN;
		else if (item.hot_temp > cfg.max_heatsink_temp)         tick_fault = cfs_pkg::FAULT_HS_HOT;
		else if (item.fan_rpm == 16'd0)                         tick_fault = cfs_pkg::FAULT_FAN;
		else                                                    tick_fault = cfs_pkg::FAULT_NONE;
	end

	always_comb begin
		nxt      = cur;
		kick     = 1'b0;
		oc_event = 1'b0;
		unique case (item.command)
			cfs_pkg::CMD_TICK: begin
				kick      = 1'b1;
				oc_event  = item.overcurrent_flag;
				nxt.fault = tick_fault;
				unique case (cur.mode)
					cfs_pkg::MODE_STARTUP: begin
						if (tick_fault != cfs_pkg::FAULT_NONE) begin
							nxt.mode = cfs_pkg::MODE_DISABLED;
						end else if (cold_ext <= stop_lvl) begin
							nxt.mode = cfs_pkg::MODE_AT_TEMP;
						end else begin
							nxt.mode     = cfs_pkg::MODE_COOLING;
							nxt.drive_on = 1'b1;
						end
					end
					cfs_pkg::MODE_AT_TEMP: begin
						if (cold_ext >= start_lvl) begin
							nxt.mode     = cfs_pkg::MODE_COOLING;
							nxt.drive_on = 1'b1;
						end
					end
					cfs_pkg::MODE_COOLING: begin
						if (item.power_fail_flag) begin
							nxt.fault = cfs_pkg::FAULT_POWER;
						end
						if (cold_ext <= stop_lvl) begin
							nxt.mode     = cfs_pkg::MODE_AT_TEMP;
							nxt.drive_on = 1'b0;
						end
					end
					default: ;
				endcase
				if (nxt.fault != cfs_pkg::FAULT_NONE) begin
					nxt.mode        = cfs_pkg::MODE_DISABLED;
					nxt.drive_on    = 1'b0;
					nxt.watchdog_on = 1'b0;
				end
			end
			cfs_pkg::CMD_START: begin
				nxt.mode        = cfs_pkg::MODE_STARTUP;
				nxt.fault       = cfs_pkg::FAULT_NONE;
				nxt.watchdog_on = 1'b1;
			end
			cfs_pkg::CMD_STOP: begin
				nxt.mode        = cfs_pkg::MODE_DISABLED;
				nxt.drive_on    = 1'b0;
				nxt.watchdog_on = 1'b0;
			end
			cfs_pkg::CMD_CLEAR: begin
				nxt.fault = cfs_pkg::FAULT_NONE;
			end
			cfs_pkg::CMD_FAST_STOP: begin
				nxt.drive_on = 1'b0;
			end
			default: ;
		endcase
	end

endmodule

FILE: design/cooler_fault_supervisor_thermostat.sv
// Top level of the cooler fault supervisor with hysteresis thermostat.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data   (cfs_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data  (cfs_pkg::out_item_t)
// cfg       input      cfg_wr_en              cfg_index, cfg_data (8 bits)
//
// Each command transaction passes through the input register and then the result
// register on its way to a result. One transaction is accepted every cycle while the
// result register is empty or being drained; the fault check and state update are
// combinational between the two registers. Reset clears the state machine, the fault
// code, the switch, the watchdog flag and both valid bits, and loads the default
// configuration. When the result register holds an untaken result, the input register
// keeps its command and in_ready stays high only while the input register is empty.
`timescale 1ns / 1ps
module cooler_fault_supervisor_thermostat (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cfs_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cfs_pkg::out_item_t  out_data,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	cfs_pkg::cfg_t      cfg;
	cfs_pkg::in_item_t  item_s1;
	logic               valid_s1;
	cfs_pkg::state_t    state_q;
	cfs_pkg::state_t    state_nxt;
	logic               kick;
	logic               oc_event;
	cfs_pkg::out_item_t out_data_q;
	logic               out_valid_q;
	logic               advance;

	cfs_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfs_step u_step (
		.item     (item_s1),
		.cfg      (cfg),
		.cur      (state_q),
		.nxt      (state_nxt),
		.kick     (kick),
		.oc_event (oc_event)
	);

	// The input register moves on whenever the result register is empty or being drained.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// State is committed at the same edge the result is loaded, so the next command
	// in the input register already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= cfs_pkg::MODE_DISABLED;
			state_q.fault       <= cfs_pkg::FAULT_NONE;
			state_q.drive_on    <= 1'b0;
			state_q.watchdog_on <= 1'b0;
			out_valid_q         <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q.drive_enable      <= state_nxt.drive_on;
			out_data_q.run_state         <= cfs_pkg::run_code(state_nxt.mode);
			out_data_q.fault_code        <= state_nxt.fault;
			out_data_q.watchdog_enabled  <= state_nxt.watchdog_on;
			out_data_q.watchdog_kick     <= kick;
			out_data_q.overcurrent_event <= oc_event;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: design/cfs_checker.sv
// Port-level checks for the cooler fault supervisor, bound to the top level.
`timescale 1ns / 1ps
module cfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input cfs_pkg::out_item_t out_data
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Any standing fault means the block has been shut down.
	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fault_code != cfs_pkg::FAULT_NONE |->
		out_data.run_state == cfs_pkg::RUN_DISABLED && !out_data.drive_enable
		&& !out_data.watchdog_enabled)
		else $error("fault present while block still enabled");

	// The cooler switch is never on while the block is disabled.
	a_drive_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_enable |-> out_data.run_state != cfs_pkg::RUN_DISABLED)
		else $error("drive on while disabled");

	// An overcurrent event only comes from a tick and always leaves a fault.
	a_oc_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overcurrent_event |-> out_data.watchdog_kick &&
		(out_data.fault_code == cfs_pkg::FAULT_OVERCUR
		|| out_data.fault_code == cfs_pkg::FAULT_GAIN
		|| out_data.fault_code == cfs_pkg::FAULT_POWER))
		else $error("overcurrent event without matching fault");

endmodule

bind cooler_fault_supervisor_thermostat cfs_checker u_cfs_checker (.*);
